@@ hdl/persistent_array_path_copy_defines.svh @@
// assertion macros for the persistent array block
// no dependencies; included by the top level only
`ifndef PERSISTENT_ARRAY_PATH_COPY_DEFINES_SVH
`define PERSISTENT_ARRAY_PATH_COPY_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PAPC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PAPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/papc_pkg.sv @@
// shared types and constants of the persistent array block
// no dependencies; used by papc_ctrl, papc_datapath and the top level
package papc_pkg;

    // field widths of the stream beats
    localparam int VER_W = 10;
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    localparam logic [CNT_W-1:0] ELEMENT_COUNT_RESET = 11'd1024;

    // defaults of the top-level parameters
    localparam int DEF_INDEX_BITS = 10;
    localparam int DEF_NODE_POOL = 4096;
    localparam int DEF_MAX_VERSIONS = 1024;
    localparam int DEF_VALUE_BITS = 32;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } papc_op_t;

    typedef enum logic [1:0] {
        ST_OK              = 2'd0,
        ST_UNKNOWN_VERSION = 2'd1,
        ST_POOL_FULL       = 2'd2,
        ST_TABLE_FULL      = 2'd3
    } papc_status_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic root_rd;
        logic first;
        logic step;
        logic load_out;
    } papc_cmd_t;

    // datapath to controller
    typedef struct packed {
        papc_status_t err;
        logic         walk_last;
        logic         out_free;
    } papc_stat_t;

endpackage

@@ hdl/papc_ctrl.sv @@
// sequencer of the persistent array block
// depends on papc_pkg (command and status structs)
module papc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  papc_pkg::papc_stat_t  stat,
    output papc_pkg::papc_cmd_t   cmd,
    output logic                  ready
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROOT  = 5'b00010,
        S_FIRST = 5'b00100,
        S_STEP  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = (stat.err != papc_pkg::ST_OK) ? S_DONE : S_ROOT;
                end
            end
            S_ROOT: begin
                cmd.root_rd = 1'b1;
                state_next = S_FIRST;
            end
            S_FIRST: begin
                cmd.first = 1'b1;
                state_next = S_STEP;
            end
            S_STEP: begin
                cmd.step = 1'b1;
                if (stat.walk_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // nothing is taken while reset is held
    assign ready = (state_reg == S_IDLE) && aresetn;

endmodule

@@ hdl/papc_datapath.sv @@
// node pool, leaf store, root table, counters and output register
// depends on papc_pkg (widths, status codes, command and status structs)
module papc_datapath #(
    parameter int INDEX_BITS   = papc_pkg::DEF_INDEX_BITS,
    parameter int NODE_POOL    = papc_pkg::DEF_NODE_POOL,
    parameter int MAX_VERSIONS = papc_pkg::DEF_MAX_VERSIONS,
    parameter int VALUE_BITS   = papc_pkg::DEF_VALUE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  papc_pkg::papc_cmd_t           cmd,
    output papc_pkg::papc_stat_t          stat,
    input  logic                          cfg_we,
    input  logic [papc_pkg::CNT_W-1:0]    cfg_data,
    input  logic                          s_command,
    input  logic [papc_pkg::VER_W-1:0]    s_version,
    input  logic [papc_pkg::IDX_W-1:0]    s_index,
    input  logic [papc_pkg::VAL_W-1:0]    s_value,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [papc_pkg::VAL_W-1:0]    m_read_value,
    output logic [papc_pkg::VER_W-1:0]    m_new_version,
    output papc_pkg::papc_status_t        m_status
);

    localparam int PTR_W = $clog2(NODE_POOL);
    localparam int NU_W = PTR_W + 1;
    localparam int VA_W = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;
    localparam int VC_W = $clog2(MAX_VERSIONS + 1);
    localparam int MAX_LEVELS = (INDEX_BITS + 1) / 2;
    localparam int LV_W = $clog2(MAX_LEVELS + 1);
    localparam int IX_W = 2 * MAX_LEVELS;
    localparam logic [IX_W-1:0] IDX_MASK = IX_W'((64'd1 << INDEX_BITS) - 64'd1);
    localparam logic [PTR_W-1:0] NULL_PTR = {PTR_W{1'b1}};

    // depth of the trie for a given element count, saturating
    function automatic logic [LV_W-1:0] depth_of(input logic [papc_pkg::CNT_W-1:0] count);
        logic [LV_W-1:0] lv;
        lv = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if ((64'd1 << (2 * i)) < 64'(count)) begin
                lv = lv + LV_W'(1);
            end
        end
        return lv;
    endfunction

    // memories
    logic [4*PTR_W-1:0]      node_mem [NODE_POOL];
    logic [VALUE_BITS-1:0]   leaf_mem [NODE_POOL];
    logic [PTR_W-1:0]        root_mem [MAX_VERSIONS];
    logic [4*PTR_W-1:0]      rd_links_reg;
    logic [VALUE_BITS-1:0]   rd_leaf_reg;
    logic [PTR_W-1:0]        root_rd_reg;

    // control state
    logic [papc_pkg::CNT_W-1:0] element_count_reg;
    logic [NU_W-1:0]            nodes_used_reg, nodes_used_next;
    logic [VC_W-1:0]            versions_used_reg, versions_used_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    // item state
    papc_pkg::papc_op_t     op_reg;
    logic [VA_W-1:0]        ver_reg;
    logic [IX_W-1:0]        idx_reg;
    logic [VALUE_BITS-1:0]  val_reg;
    logic [LV_W-1:0]        levels_reg;
    logic [LV_W-1:0]        lv_reg;
    logic [PTR_W-1:0]       nn_reg;
    logic                   ok_reg;
    logic                   zero_reg;
    papc_pkg::papc_status_t res_status_reg;
    logic [papc_pkg::VAL_W-1:0] res_value_reg;
    logic [papc_pkg::VER_W-1:0] res_ver_reg;
    logic [papc_pkg::VAL_W-1:0] m_value_reg;
    logic [papc_pkg::VER_W-1:0] m_ver_reg;
    papc_pkg::papc_status_t     m_status_reg;

    // combinational
    logic [LV_W-1:0]        cfg_levels;
    papc_pkg::papc_status_t acc_err;
    logic [PTR_W-1:0]       link_a [4];
    logic [PTR_W-1:0]       new_link [4];
    logic [4*PTR_W-1:0]     new_links_vec;
    logic [VALUE_BITS-1:0]  leaf_eff, leaf_new;
    logic [LV_W:0]          sh;
    logic [1:0]             slot;
    logic [PTR_W-1:0]       next_p, root_p, fetch_addr;
    logic                   fetch_en, ok_next, zero_next;
    logic                   walk_last, node_we, root_we, node_live;

    assign cfg_levels = depth_of(element_count_reg);

    // admission checks; unknown version wins
    always_comb begin
        acc_err = papc_pkg::ST_OK;
        priority if (32'(s_version) >= 32'(versions_used_reg)) begin
            acc_err = papc_pkg::ST_UNKNOWN_VERSION;
        end else if (s_command == papc_pkg::OP_WRITE &&
                     32'(versions_used_reg) >= 32'(MAX_VERSIONS)) begin
            acc_err = papc_pkg::ST_TABLE_FULL;
        end else if (s_command == papc_pkg::OP_WRITE &&
                     32'(nodes_used_reg) + 32'(cfg_levels) + 32'd1 > 32'(NODE_POOL - 1)) begin
            acc_err = papc_pkg::ST_POOL_FULL;
        end else begin
            acc_err = papc_pkg::ST_OK;
        end
    end

    // node zero is decoded as the empty node, a dead pointer reads the same
    assign node_live = ok_reg && !zero_reg;
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            link_a[j] = node_live ? rd_links_reg[j*PTR_W +: PTR_W] : NULL_PTR;
        end
    end
    assign leaf_eff = node_live ? rd_leaf_reg : '0;

    assign sh = {lv_reg - LV_W'(1), 1'b0};
    assign slot = 2'(idx_reg >> sh);
    assign next_p = link_a[slot];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            new_link[j] = (2'(j) == slot && lv_reg != '0) ? (nn_reg + PTR_W'(1)) : link_a[j];
            new_links_vec[j*PTR_W +: PTR_W] = new_link[j];
        end
    end
    assign leaf_new = (lv_reg == '0) ? val_reg : leaf_eff;

    assign walk_last = (lv_reg == '0) || (op_reg == papc_pkg::OP_READ && !ok_reg);
    assign node_we = cmd.step && op_reg == papc_pkg::OP_WRITE;
    assign root_we = node_we && lv_reg == '0;

    assign root_p = (ver_reg == '0) ? '0 : root_rd_reg;
    assign fetch_addr = cmd.first ? root_p : next_p;
    assign fetch_en = cmd.first || cmd.step;
    assign ok_next = (fetch_addr != NULL_PTR) && (NU_W'(fetch_addr) < nodes_used_reg);
    assign zero_next = (fetch_addr == '0);

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[nn_reg] <= new_links_vec;
            leaf_mem[nn_reg] <= leaf_new;
        end
        if (fetch_en) begin
            rd_links_reg <= node_mem[fetch_addr];
            rd_leaf_reg <= leaf_mem[fetch_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (root_we) begin
            root_mem[VA_W'(versions_used_reg)] <= PTR_W'(nodes_used_reg);
        end
        if (cmd.root_rd) begin
            root_rd_reg <= root_mem[ver_reg];
        end
    end

    always_comb begin
        nodes_used_next = nodes_used_reg;
        versions_used_next = versions_used_reg;
        if (root_we) begin
            nodes_used_next = nodes_used_reg + NU_W'(levels_reg) + NU_W'(1);
            versions_used_next = versions_used_reg + VC_W'(1);
        end
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg <= papc_pkg::ELEMENT_COUNT_RESET;
            nodes_used_reg <= NU_W'(1);
            versions_used_reg <= VC_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                element_count_reg <= cfg_data;
            end
            nodes_used_reg <= nodes_used_next;
            versions_used_reg <= versions_used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg <= papc_pkg::papc_op_t'(s_command);
            ver_reg <= VA_W'(s_version);
            idx_reg <= IX_W'(s_index) & IDX_MASK;
            val_reg <= VALUE_BITS'(s_value);
            levels_reg <= cfg_levels;
            lv_reg <= cfg_levels;
            nn_reg <= PTR_W'(nodes_used_reg);
            res_status_reg <= acc_err;
            res_value_reg <= '0;
            res_ver_reg <= '0;
        end
        if (fetch_en) begin
            ok_reg <= ok_next;
            zero_reg <= zero_next;
        end
        if (cmd.step) begin
            if (walk_last) begin
                if (op_reg == papc_pkg::OP_READ) begin
                    res_value_reg <= papc_pkg::VAL_W'(leaf_eff);
                end else begin
                    res_ver_reg <= papc_pkg::VER_W'(versions_used_reg);
                end
            end else begin
                lv_reg <= lv_reg - LV_W'(1);
                nn_reg <= nn_reg + PTR_W'(1);
            end
        end
        if (cmd.load_out) begin
            m_value_reg <= res_value_reg;
            m_ver_reg <= res_ver_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign stat.err = acc_err;
    assign stat.walk_last = walk_last;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_read_value = m_value_reg;
    assign m_new_version = m_ver_reg;
    assign m_status = m_status_reg;

endmodule

@@ hdl/persistent_array_path_copy.sv @@
// top level of the persistent array: versioned 4-ary trie with path copying
// depends on papc_pkg, papc_ctrl, papc_datapath and the assertion macro header
//
// use:
//   s_ channel carries one read or write per beat, m_ channel one result per beat
//   cfg_ channel sets element_count (trie depth L = ceil(log4(count)), saturating)
//   one item at a time; each trie level takes one access of the node memory port,
//   read data feeding the next address directly
//   a write or a full read walks every level, a read that meets a null link stops early,
//   and a rejected item goes straight to its result without a walk
//   the next beat is taken while an earlier result still waits in the output register
//   a stalled m_ channel holds the finished result in the datapath, the sequencer waiting in S_DONE until taken
//   reset: no beat and no register write is taken while aresetn is low;
//   afterwards one version (the empty array) and one node in use, element_count 1024;
//   node zero and version zero are decoded, so no clearing pass is run
//   statuses: ok, unknown version, node pool full, version table full;
//   an error result changes nothing
`include "persistent_array_path_copy_defines.svh"

module persistent_array_path_copy #(
    parameter int INDEX_BITS   = papc_pkg::DEF_INDEX_BITS,
    parameter int NODE_POOL    = papc_pkg::DEF_NODE_POOL,
    parameter int MAX_VERSIONS = papc_pkg::DEF_MAX_VERSIONS,
    parameter int VALUE_BITS   = papc_pkg::DEF_VALUE_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write, element_count
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [papc_pkg::CNT_W-1:0]        cfg_data,
    // input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [papc_pkg::S_TDATA_W-1:0]    s_tdata,   // version[9:0], index[19:10], write_value[51:20]
    input  logic                              s_tuser,   // command[0]
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [papc_pkg::M_TDATA_W-1:0]    m_tdata,   // read_value[31:0], new_version[41:32]
    output logic [1:0]                        m_tuser    // status[1:0]
);

    localparam int VER_LO = 0;
    localparam int IDX_LO = VER_LO + papc_pkg::VER_W;
    localparam int VAL_LO = IDX_LO + papc_pkg::IDX_W;
    localparam int M_PAD = papc_pkg::M_TDATA_W - papc_pkg::VAL_W - papc_pkg::VER_W;

    papc_pkg::papc_cmd_t        cmd;
    papc_pkg::papc_stat_t       stat;
    papc_pkg::papc_status_t     m_status;
    logic [papc_pkg::VAL_W-1:0] m_read_value;
    logic [papc_pkg::VER_W-1:0] m_new_version;

    // register writes are taken whenever out of reset
    assign cfg_ready = aresetn;

    papc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .ready    (s_tready)
    );

    papc_datapath #(
        .INDEX_BITS   (INDEX_BITS),
        .NODE_POOL    (NODE_POOL),
        .MAX_VERSIONS (MAX_VERSIONS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .s_command     (s_tuser),
        .s_version     (s_tdata[VER_LO +: papc_pkg::VER_W]),
        .s_index       (s_tdata[IDX_LO +: papc_pkg::IDX_W]),
        .s_value       (s_tdata[VAL_LO +: papc_pkg::VAL_W]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_read_value  (m_read_value),
        .m_new_version (m_new_version),
        .m_status      (m_status)
    );

    // pack the result beat, padding bits are zero
    assign m_tdata = {{M_PAD{1'b0}}, m_new_version, m_read_value};
    assign m_tuser = m_status;

    // an accepted beat always starts a walk or an error result
    `PAPC_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while busy")
    // a result only moves into a free output register
    `PAPC_ASSERT_NOW(a_load_when_free, aclk, aresetn, cmd.load_out, !m_tvalid || m_tready, "result overwrote a waiting beat")
    // the loaded result shows up on the next cycle
    `PAPC_ASSERT_NEXT(a_load_raises_valid, aclk, aresetn, cmd.load_out, m_tvalid, "loaded result not presented")
    // the sequencer issues one command at a time
    `PAPC_ASSERT_NOW(a_single_command, aclk, aresetn, 1'b1, $onehot0(cmd), "several datapath commands at once")

endmodule

@@ test/tb_persistent_array_path_copy.sv @@
// self-checking testbench for persistent_array_path_copy: versioned 4-ary trie with path copying
// depends on papc_pkg and the persistent_array_path_copy rtl; needs no files or arguments
// a behavioural trie in the bench predicts every result beat, which is compared field by field
module tb_persistent_array_path_copy;

    // sizes of the default build
    localparam int POOL_NODES    = papc_pkg::DEF_NODE_POOL;
    localparam int VERSIONS      = papc_pkg::DEF_MAX_VERSIONS;
    localparam int MAX_DEPTH     = (papc_pkg::DEF_INDEX_BITS + 1) / 2;
    localparam int NODE_W        = $clog2(papc_pkg::DEF_NODE_POOL);
    localparam logic [NODE_W-1:0] NULL_NODE = '1;
    // settling time at the end, long enough for any beat still in flight
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    // one access as it goes into the block
    typedef struct packed {
        papc_pkg::papc_op_t         op;
        logic [papc_pkg::VER_W-1:0] version;
        logic [papc_pkg::IDX_W-1:0] index;
        logic [papc_pkg::VAL_W-1:0] value;
    } trie_access_t;

    // one result beat as the trie model works it out
    typedef struct {
        logic [papc_pkg::VAL_W-1:0] read_value;
        logic [papc_pkg::VER_W-1:0] new_version;
        papc_pkg::papc_status_t     status;
    } trie_outcome_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [papc_pkg::CNT_W-1:0]       cfg_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [papc_pkg::S_TDATA_W-1:0]   s_tdata;   // version[9:0], index[19:10], write_value[51:20]
    logic                             s_tuser;   // command[0]
    logic                             m_tvalid;
    logic                             m_tready;
    logic [papc_pkg::M_TDATA_W-1:0]   m_tdata;   // read_value[31:0], new_version[41:32]
    logic [1:0]                       m_tuser;   // status[1:0]

    // bench copy of the trie: links, leaf values, version roots and the allocation counts
    logic [NODE_W-1:0]          trie_link [POOL_NODES][4];
    logic [papc_pkg::VAL_W-1:0] leaf_value [POOL_NODES];
    logic [NODE_W-1:0]          version_root [VERSIONS];
    int                         nodes_used;
    int                         versions_used;
    logic [papc_pkg::CNT_W-1:0] element_count_cfg;

    trie_outcome_t              awaited_outcomes [$];
    logic [papc_pkg::IDX_W-1:0] recent_indices [$];

    int idle_pct;
    int stall_pct;
    int hold_off_cycles;
    int accesses_issued;
    int writes_issued;
    int outcomes_checked;
    int mismatch_count;
    int settings_written;
    int status_tally [4];

    trie_outcome_t seen_outcome;

    persistent_array_path_copy DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // trie model
    // ------------------------------------------------------------------

    // inner levels for a given element count, ceiling log4, saturating
    function automatic int trie_depth(logic [papc_pkg::CNT_W-1:0] count);
        int lv;
        lv = 0;
        while (lv < MAX_DEPTH && (64'd1 << (2 * lv)) < count)
            lv++;
        return lv;
    endfunction

    // a pointer is followed only when it is not null and already allocated
    function automatic bit node_live(logic [NODE_W-1:0] p);
        return p != NULL_NODE && int'(p) < nodes_used;
    endfunction

    // applies one access to the bench trie and returns the beat it should produce
    function automatic trie_outcome_t apply_to_trie(trie_access_t acc);
        trie_outcome_t     res;
        int                depth;
        int                lv;
        int                k;
        int                s;
        int                slot;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nxt;
        logic [NODE_W-1:0] nn;
        res.read_value  = '0;
        res.new_version = '0;
        res.status      = papc_pkg::ST_OK;
        depth = trie_depth(element_count_cfg);

        // unknown version is checked before anything else, reads included
        if (int'(acc.version) >= versions_used) begin
            res.status = papc_pkg::ST_UNKNOWN_VERSION;
            return res;
        end
        cur = version_root[acc.version];

        // read: walk two index bits per level, most significant pair first
        if (acc.op == papc_pkg::OP_READ) begin
            lv = depth;
            while (lv > 0 && node_live(cur)) begin
                slot = int'((acc.index >> (2 * (lv - 1))) & 10'd3);
                cur  = trie_link[cur][slot];
                lv--;
            end
            if (node_live(cur))
                res.read_value = leaf_value[cur];
            return res;
        end

        if (versions_used >= VERSIONS) begin
            res.status = papc_pkg::ST_TABLE_FULL;
            return res;
        end
        // the all-ones node is never handed out, so the pool is one short
        if (nodes_used + depth + 1 > POOL_NODES - 1) begin
            res.status = papc_pkg::ST_POOL_FULL;
            return res;
        end

        // path copy: fresh nodes in a chain, each new node pointing at the next
        for (k = 0; k <= depth; k++) begin
            nn = NODE_W'(nodes_used + k);
            if (node_live(cur)) begin
                for (s = 0; s < 4; s++)
                    trie_link[nn][s] = trie_link[cur][s];
                leaf_value[nn] = leaf_value[cur];
            end else begin
                for (s = 0; s < 4; s++)
                    trie_link[nn][s] = NULL_NODE;
                leaf_value[nn] = '0;
            end
            if (k < depth) begin
                slot = int'((acc.index >> (2 * (depth - 1 - k))) & 10'd3);
                nxt  = node_live(cur) ? trie_link[cur][slot] : NULL_NODE;
                trie_link[nn][slot] = nn + 1'b1;
                cur = nxt;
            end else begin
                leaf_value[nn] = acc.value;
            end
        end
        version_root[versions_used] = NODE_W'(nodes_used);
        nodes_used += depth + 1;
        res.new_version = papc_pkg::VER_W'(versions_used);
        versions_used++;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, long hold-off and the beat checker
    // ------------------------------------------------------------------

    // receiver: a pending hold-off wins over the random stall rate
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on result beat %0d: %s expected %0h got %0h",
                     outcomes_checked, field, want, got);
    endtask

    // every accepted result beat is matched against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            outcomes_checked++;
            if (awaited_outcomes.size() == 0) begin
                note_mismatch("beat with nothing pending, status", '0, 32'(m_tuser));
            end else begin
                seen_outcome = awaited_outcomes.pop_front();
                if (m_tdata[31:0] !== seen_outcome.read_value)
                    note_mismatch("read_value", seen_outcome.read_value, m_tdata[31:0]);
                if (m_tdata[41:32] !== seen_outcome.new_version)
                    note_mismatch("new_version", 32'(seen_outcome.new_version),
                                  32'(m_tdata[41:32]));
                if (m_tuser !== seen_outcome.status)
                    note_mismatch("status", 32'(seen_outcome.status), 32'(m_tuser));
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    task automatic set_idling(int send_idle, int recv_stall);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
    endtask

    // offers one beat after a random gap; the prediction is made at the accepting edge.
    // tvalid is left high on return: the next call or a drain decides its next value
    task automatic issue_access(papc_pkg::papc_op_t op, logic [papc_pkg::VER_W-1:0] ver,
                                logic [papc_pkg::IDX_W-1:0] idx,
                                logic [papc_pkg::VAL_W-1:0] val);
        trie_access_t  acc;
        trie_outcome_t res;
        acc.op      = op;
        acc.version = ver;
        acc.index   = idx;
        acc.value   = val;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(papc_pkg::S_TDATA_W - papc_pkg::VAL_W - papc_pkg::IDX_W
                       - papc_pkg::VER_W){1'b0}}, val, idx, ver};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        res = apply_to_trie(acc);
        status_tally[int'(res.status)]++;
        awaited_outcomes.insert(awaited_outcomes.size(), res);
        accesses_issued++;
        if (op == papc_pkg::OP_WRITE)
            writes_issued++;
    endtask

    // sender goes quiet until every predicted beat has come back
    task automatic drain_outcomes();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_outcomes.size() != 0);
    endtask

    // only called with the block drained
    task automatic write_element_count(logic [papc_pkg::CNT_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        element_count_cfg = count;
        settings_written++;
    endtask

    // mostly recent versions so reads land on populated paths, some unknown ones
    function automatic logic [papc_pkg::VER_W-1:0] pick_version();
        int top;
        int roll;
        top  = versions_used - 1;
        roll = $urandom_range(99);
        if (roll < 10)
            return papc_pkg::VER_W'($urandom_range(VERSIONS - 1));
        if (roll < 55)
            return papc_pkg::VER_W'(top - $urandom_range(top < 8 ? top : 8));
        return papc_pkg::VER_W'($urandom_range(top));
    endfunction

    function automatic logic [papc_pkg::IDX_W-1:0] pick_index();
        if (recent_indices.size() != 0 && $urandom_range(1) == 1)
            return recent_indices[$urandom_range(recent_indices.size() - 1)];
        return papc_pkg::IDX_W'($urandom_range(1023));
    endfunction

    task automatic issue_random_access(int write_pct);
        papc_pkg::papc_op_t         op;
        logic [papc_pkg::IDX_W-1:0] idx;
        logic [papc_pkg::VAL_W-1:0] val;
        op  = ($urandom_range(99) < write_pct) ? papc_pkg::OP_WRITE : papc_pkg::OP_READ;
        idx = pick_index();
        case ($urandom_range(7))
            0: val = '0;
            1: val = '1;
            default: val = $urandom;
        endcase
        issue_access(op, pick_version(), idx, val);
        if (op == papc_pkg::OP_WRITE) begin
            recent_indices.insert(recent_indices.size(), idx);
            if (recent_indices.size() > 16)
                void'(recent_indices.pop_front());
        end
    endtask

    // write on a random known version, used while running the allocators dry
    task automatic issue_filler_write();
        issue_access(papc_pkg::OP_WRITE, papc_pkg::VER_W'($urandom_range(versions_used - 1)),
                     papc_pkg::IDX_W'($urandom_range(1023)), $urandom);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // fresh block: version zero is all zeros, everything else unknown
    task automatic test_empty_array();
        set_idling(0, 0);
        issue_access(papc_pkg::OP_READ, 10'd0, 10'd0, '0);
        issue_access(papc_pkg::OP_READ, 10'd0, 10'd1023, 32'hFFFF_FFFF);
        issue_access(papc_pkg::OP_READ, 10'd1, 10'd0, '0);
        issue_access(papc_pkg::OP_READ, 10'd1023, 10'd1023, '0);
        issue_access(papc_pkg::OP_WRITE, 10'd5, 10'd3, 32'hDEAD_BEEF);
    endtask

    // full depth paths: extremes of index and value, branching off older versions
    task automatic test_path_copies();
        drain_outcomes();
        set_idling(0, 0);
        issue_access(papc_pkg::OP_WRITE, 10'd0, 10'd0, 32'hFFFF_FFFF);
        issue_access(papc_pkg::OP_WRITE, 10'd1, 10'd1023, 32'h0000_0000);
        issue_access(papc_pkg::OP_WRITE, 10'd2, 10'd1023, 32'h8000_0001);
        issue_access(papc_pkg::OP_READ, 10'd3, 10'd1023, '0);
        issue_access(papc_pkg::OP_READ, 10'd2, 10'd1023, '0);
        issue_access(papc_pkg::OP_READ, 10'd3, 10'd0, '0);
        issue_access(papc_pkg::OP_READ, 10'd0, 10'd0, '0);
        // diverges from every written path at the top level
        issue_access(papc_pkg::OP_READ, 10'd3, 10'h155, '0);
        issue_access(papc_pkg::OP_WRITE, 10'd1, 10'd0, 32'h1234_5678);
        issue_access(papc_pkg::OP_READ, 10'd4, 10'd0, '0);
        issue_access(papc_pkg::OP_READ, 10'd1, 10'd0, '0);
    endtask

    // depth zero (every index aliases), depth one, and a saturating count
    task automatic test_depth_settings();
        drain_outcomes();
        write_element_count(11'd0);
        issue_access(papc_pkg::OP_WRITE, 10'd3, 10'd7, 32'h5A5A_A5A5);
        issue_access(papc_pkg::OP_READ, 10'd5, 10'd1000, '0);
        issue_access(papc_pkg::OP_READ, 10'd3, 10'd0, '0);
        drain_outcomes();
        write_element_count(11'd4);
        issue_access(papc_pkg::OP_READ, 10'd5, 10'd1, '0);
        issue_access(papc_pkg::OP_WRITE, 10'd5, 10'd1022, 32'h0F0F_F0F0);
        issue_access(papc_pkg::OP_READ, 10'd6, 10'd2, '0);
        drain_outcomes();
        write_element_count(11'd2047);
        issue_access(papc_pkg::OP_READ, 10'd3, 10'd1023, '0);
        issue_access(papc_pkg::OP_WRITE, 10'd6, 10'd512, 32'h7FFF_FFFF);
    endtask

    // eight phases, each with its own element_count; the four idling patterns each run twice
    task automatic test_random_accesses();
        logic [papc_pkg::CNT_W-1:0] count;
        for (int p = 0; p < 8; p++) begin
            drain_outcomes();
            case (p)
                0: count = 11'd1024;
                1: count = 11'd0;
                2: count = 11'd2047;
                3: count = 11'd16;
                4: count = 11'd5;
                5: count = 11'd1;
                6: count = papc_pkg::CNT_W'($urandom_range(2047));
                default: count = 11'd64;
            endcase
            write_element_count(count);
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(70, 0);
                2: set_idling(0, 70);
                default: set_idling(30, 30);
            endcase
            repeat (62) issue_random_access(45);
        end
    endtask

    // receiver holds off long enough that the block fills and stops taking beats
    task automatic test_result_backpressure();
        drain_outcomes();
        write_element_count(11'd1024);
        set_idling(0, 0);
        hold_off_cycles = 300;
        repeat (10) issue_random_access(50);
    endtask

    // runs the node pool dry, then the version table, then reads across all versions
    task automatic test_pool_and_table_exhaustion();
        drain_outcomes();
        write_element_count(11'd1024);
        set_idling(30, 30);
        // deep writes until spare nodes exceed spare versions by less than one depth
        while ((POOL_NODES - 1 - nodes_used) - (VERSIONS - versions_used) >= MAX_DEPTH &&
               VERSIONS - versions_used > 1)
            issue_filler_write();
        // single-node writes down to too few nodes for a full depth path
        drain_outcomes();
        write_element_count(11'd1);
        while (POOL_NODES - 1 - nodes_used > MAX_DEPTH)
            issue_filler_write();
        // a full depth write now finds the pool short
        drain_outcomes();
        write_element_count(11'd1024);
        issue_filler_write();
        issue_access(papc_pkg::OP_READ, papc_pkg::VER_W'(versions_used - 1), 10'd0, '0);
        // the nodes left cover the versions left, so the table fills next
        drain_outcomes();
        write_element_count(11'd0);
        while (versions_used < VERSIONS)
            issue_filler_write();
        issue_filler_write();
        // every version is known now, the top one included
        issue_access(papc_pkg::OP_READ, 10'd1023, 10'd1023, '0);
        drain_outcomes();
        write_element_count(11'd1024);
        repeat (15) issue_access(papc_pkg::OP_READ, papc_pkg::VER_W'($urandom_range(1023)),
                                 papc_pkg::IDX_W'($urandom_range(1023)), '0);
        drain_outcomes();
        write_element_count(11'd16);
        repeat (15) issue_access(papc_pkg::OP_READ, papc_pkg::VER_W'($urandom_range(1023)),
                                 papc_pkg::IDX_W'($urandom_range(1023)), '0);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;

        // bench trie in its reset state: version zero is the empty root node
        for (int s = 0; s < 4; s++)
            trie_link[0][s] = NULL_NODE;
        leaf_value[0]     = '0;
        version_root[0]   = '0;
        nodes_used        = 1;
        versions_used     = 1;
        element_count_cfg = papc_pkg::ELEMENT_COUNT_RESET;

        idle_pct         = 0;
        stall_pct        = 0;
        hold_off_cycles  = 0;
        accesses_issued  = 0;
        writes_issued    = 0;
        outcomes_checked = 0;
        mismatch_count   = 0;
        settings_written = 0;
        for (int i = 0; i < 4; i++)
            status_tally[i] = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_array();
        test_path_copies();
        test_depth_settings();
        test_random_accesses();
        test_result_backpressure();
        test_pool_and_table_exhaustion();

        drain_outcomes();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run covered %0d accesses (%0d writes) over %0d element_count settings, %0d result beats checked",
                 accesses_issued, writes_issued, settings_written, outcomes_checked);
        $display("statuses: ok %0d, unknown version %0d, pool full %0d, table full %0d; mismatches %0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("** persistent_array_path_copy: PASSED **");
        end else begin
            $display("** persistent_array_path_copy: FAILED **");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("timeout with %0d result beats still awaited", awaited_outcomes.size());
        $display("** persistent_array_path_copy: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/papc_pkg.sv
hdl/papc_ctrl.sv
hdl/papc_datapath.sv
hdl/persistent_array_path_copy.sv
test/tb_persistent_array_path_copy.sv
